// File: rtl/fsh_pkg.sv
`timescale 1ns / 1ps

package fsh_pkg;

   // widths of the sample path
   localparam int unsigned RAW_W    = 24;
   localparam int unsigned STAMP_W  = 32;
   localparam int unsigned FORCE_W  = 16;
   localparam int unsigned SCALE_W  = 32;
   localparam int unsigned THR_W    = 16;
   localparam int unsigned RUN_W    = 8;
   localparam int unsigned DELTA_W  = RAW_W + 1;
   localparam int unsigned PROD_W   = DELTA_W + SCALE_W;
   localparam int unsigned Q_FRAC_BITS = 24;

   // csr bus
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_IDX_W  = 3;

   localparam logic [FORCE_W-1:0] FORCE_MAX_MN = FORCE_W'(60000);
   localparam logic [RUN_W-1:0]   RUN_MAX      = '1;

   // register reset values
   localparam logic [RAW_W-1:0]   ZERO_OFFSET_RST    = '0;
   localparam logic [SCALE_W-1:0] SCALE_Q24_RST      = SCALE_W'(16777);
   localparam logic [THR_W-1:0]   DOWN_THRESHOLD_RST = THR_W'(150);
   localparam logic [THR_W-1:0]   UP_THRESHOLD_RST   = THR_W'(75);
   localparam logic [RUN_W-1:0]   DEBOUNCE_COUNT_RST = RUN_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ZERO_OFFSET    = 3'd0,
      REG_SCALE_Q24      = 3'd1,
      REG_DOWN_THRESHOLD = 3'd2,
      REG_UP_THRESHOLD   = 3'd3,
      REG_DEBOUNCE_COUNT = 3'd4
   } reg_idx_type;

   typedef enum logic {
      PEN_UP   = 1'b0,
      PEN_DOWN = 1'b1
   } pen_state_type;

endpackage

// File: rtl/force_scale_pen_hysteresis.sv
`timescale 1ns / 1ps

// force_scale_pen_hysteresis
// converts strain-gauge adc samples to a clamped force in mN and tracks a
// debounced pen-down state with separate down and up thresholds
// channels:
//   req_*  : one sample per transfer (raw_code, timestamp), valid/stall
//   rsp_*  : one result per sample (load_mn, stamp_out, pen_is_down)
//   apb    : psel/penable/pwrite/paddr/pwdata/prdata/pready, pready tied
//            high; registers at byte addresses 0,4,8,12,16
// path: a req transfer loads the input register, then the offset/multiply/
//   clamp/pen update results load the result register behind rsp_valid
// throughput: one sample per cycle while not stalled; the multiply and pen
//   update share one stage, so a sample sees the pen state the last one left
// stall: while rsp_stall holds a result, the input register still takes one
//   more sample; req_stall rises only when both registers are full
// reset (synchronous, active high): both registers empty, pen up, run
//   counters zero, csr registers back to their defaults
// write csr only while no sample is in flight

module force_scale_pen_hysteresis (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fsh_pkg::RAW_W-1:0]    req_raw_code,
   input  logic        [fsh_pkg::STAMP_W-1:0]  req_timestamp,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [fsh_pkg::FORCE_W-1:0]  rsp_load_mn,
   output logic        [fsh_pkg::STAMP_W-1:0]  rsp_stamp_out,
   output logic                                rsp_pen_is_down,
   // csr port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [fsh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [fsh_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [fsh_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import fsh_pkg::*;

   // ---------------------------------------------------------------
   // csr registers
   // ---------------------------------------------------------------
   logic signed [RAW_W-1:0]   zero_offset_ff;
   logic signed [SCALE_W-1:0] scale_q24_ff;
   logic        [THR_W-1:0]   down_threshold_ff;
   logic        [THR_W-1:0]   up_threshold_ff;
   logic        [RUN_W-1:0]   debounce_count_ff;

   logic        csr_wr;
   reg_idx_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff    <= ZERO_OFFSET_RST;
         scale_q24_ff      <= SCALE_Q24_RST;
         down_threshold_ff <= DOWN_THRESHOLD_RST;
         up_threshold_ff   <= UP_THRESHOLD_RST;
         debounce_count_ff <= DEBOUNCE_COUNT_RST;
      end else if (csr_wr) begin
         // indexes past the last register are dropped
         case (csr_idx)
            REG_ZERO_OFFSET:    zero_offset_ff    <= pwdata[RAW_W-1:0];
            REG_SCALE_Q24:      scale_q24_ff      <= pwdata[SCALE_W-1:0];
            REG_DOWN_THRESHOLD: down_threshold_ff <= pwdata[THR_W-1:0];
            REG_UP_THRESHOLD:   up_threshold_ff   <= pwdata[THR_W-1:0];
            REG_DEBOUNCE_COUNT: debounce_count_ff <= pwdata[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux, signed registers come back sign extended
   always_comb begin
      case (csr_idx)
         REG_ZERO_OFFSET:    prdata = CSR_DATA_W'(zero_offset_ff);
         REG_SCALE_Q24:      prdata = CSR_DATA_W'(scale_q24_ff);
         REG_DOWN_THRESHOLD: prdata = {{(CSR_DATA_W-THR_W){1'b0}}, down_threshold_ff};
         REG_UP_THRESHOLD:   prdata = {{(CSR_DATA_W-THR_W){1'b0}}, up_threshold_ff};
         REG_DEBOUNCE_COUNT: prdata = {{(CSR_DATA_W-RUN_W){1'b0}}, debounce_count_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // flow control: input register feeds the result register
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_adv;    // result register can load this cycle
   logic req_xfer;
   logic move;       // sample leaves the input register

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_adv;
   assign req_xfer  = req_valid && !req_stall;
   assign move      = s1_valid_ff && out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (out_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // input register payload
   logic signed [RAW_W-1:0]   s1_raw_ff;
   logic        [STAMP_W-1:0] s1_stamp_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_raw_ff   <= req_raw_code;
         s1_stamp_ff <= req_timestamp;
      end
   end

   // ---------------------------------------------------------------
   // force: (raw - offset) * scale, truncated Q.24, clamped 0..60000
   // ---------------------------------------------------------------
   logic signed [DELTA_W-1:0]  delta;
   logic signed [PROD_W-1:0]   prod;
   logic        [PROD_W-Q_FRAC_BITS-1:0] whole_mn;
   logic        [FORCE_W-1:0]  force_val;

   assign delta    = DELTA_W'(s1_raw_ff) - DELTA_W'(zero_offset_ff);
   assign prod     = PROD_W'(delta) * PROD_W'(scale_q24_ff);
   assign whole_mn = prod[PROD_W-1:Q_FRAC_BITS];

   always_comb begin
      priority if (prod[PROD_W-1] || prod == '0) begin
         force_val = '0;
      end else if (whole_mn > (PROD_W-Q_FRAC_BITS)'(FORCE_MAX_MN)) begin
         force_val = FORCE_MAX_MN;
      end else begin
         force_val = whole_mn[FORCE_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // pen state machine with debounce
   // ---------------------------------------------------------------
   pen_state_type pen_ff, pen_in;
   logic [RUN_W-1:0] down_run_ff, down_run_in;
   logic [RUN_W-1:0] up_run_ff, up_run_in;
   logic [RUN_W-1:0] down_bump, up_bump;

   // run counters saturate instead of wrapping
   assign down_bump = (down_run_ff == RUN_MAX) ? RUN_MAX : down_run_ff + 1'b1;
   assign up_bump   = (up_run_ff == RUN_MAX) ? RUN_MAX : up_run_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff      <= PEN_UP;
         down_run_ff <= '0;
         up_run_ff   <= '0;
      end else if (move) begin
         pen_ff      <= pen_in;
         down_run_ff <= down_run_in;
         up_run_ff   <= up_run_in;
      end
   end

   always_comb begin
      pen_in      = pen_ff;
      down_run_in = down_run_ff;
      up_run_in   = up_run_ff;
      unique case (pen_ff)
         PEN_UP: begin
            if (force_val >= down_threshold_ff) begin
               down_run_in = down_bump;
               if (down_bump >= debounce_count_ff) begin
                  pen_in    = PEN_DOWN;
                  up_run_in = '0;
               end
            end else begin
               down_run_in = '0;
            end
         end
         PEN_DOWN: begin
            if (force_val <= up_threshold_ff) begin
               up_run_in = up_bump;
               if (up_bump >= debounce_count_ff) begin
                  pen_in      = PEN_UP;
                  down_run_in = '0;
               end
            end else begin
               up_run_in = '0;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   logic [FORCE_W-1:0] rsp_force_ff;
   logic [STAMP_W-1:0] rsp_stamp_ff;
   logic               rsp_pen_ff;

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_force_ff <= force_val;
         rsp_stamp_ff <= s1_stamp_ff;
         rsp_pen_ff   <= (pen_in == PEN_DOWN);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_load_mn     = rsp_force_ff;
   assign rsp_stamp_out   = rsp_stamp_ff;
   assign rsp_pen_is_down = rsp_pen_ff;

endmodule

// File: rtl/fsh_checker.sv
`timescale 1ns / 1ps

module fsh_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [fsh_pkg::FORCE_W-1:0]        rsp_load_mn,
   input logic [fsh_pkg::STAMP_W-1:0]        rsp_stamp_out,
   input logic                               rsp_pen_is_down,
   input logic                               pready
);
   import fsh_pkg::*;

   // force never leaves the clamp range
   a_force_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_load_mn <= FORCE_MAX_MN)
      else $error("force above clamp limit");

   // input side only backs up when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req_stall without a stalled result");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_load_mn)
         && $stable(rsp_stamp_out) && $stable(rsp_pen_is_down))
      else $error("stalled result changed");

   // csr port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind force_scale_pen_hysteresis fsh_checker u_fsh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_load_mn     (rsp_load_mn),
   .rsp_stamp_out   (rsp_stamp_out),
   .rsp_pen_is_down (rsp_pen_is_down),
   .pready          (pready)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import fsh_pkg::*;

   // run limits
   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned SETTING_ITEMS  = 70;
   localparam int unsigned LONG_RUN_ITEMS = 300;

   // addresses past the last register, writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   // what a run of random samples aims at
   typedef enum int {
      BURST_PRESS,
      BURST_RELEASE,
      BURST_MIDDLE,
      BURST_NOISE
   } burst_kind_type;

   // one expected result
   typedef struct {
      logic [FORCE_W-1:0] load_mn;
      logic [STAMP_W-1:0] stamp;
      pen_state_type      pen;
   } pen_result_type;

   // block ports, every input driven to a known value from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [RAW_W-1:0]   req_raw_code = '0;
   logic [STAMP_W-1:0]        req_timestamp = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [FORCE_W-1:0]        rsp_load_mn;
   logic [STAMP_W-1:0]        rsp_stamp_out;
   logic                      rsp_pen_is_down;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   // shadow copy of the csr registers
   logic signed [RAW_W-1:0]   zero_offset_q = ZERO_OFFSET_RST;
   logic signed [SCALE_W-1:0] scale_q       = SCALE_Q24_RST;
   logic [THR_W-1:0]          down_thr_q    = DOWN_THRESHOLD_RST;
   logic [THR_W-1:0]          up_thr_q      = UP_THRESHOLD_RST;
   logic [RUN_W-1:0]          debounce_q    = DEBOUNCE_COUNT_RST;

   // shadow copy of the pen machine
   pen_state_type             pen_q      = PEN_UP;
   logic [RUN_W-1:0]          down_run_q = '0;
   logic [RUN_W-1:0]          up_run_q   = '0;

   // results still owed by the block, oldest first
   pen_result_type            pending_results[$];

   // idle rates in percent per cycle
   int unsigned               send_idle_pct = 0;
   int unsigned               recv_idle_pct = 0;

   int unsigned               fail_count = 0;
   int unsigned               cycle_count = 0;
   int unsigned               sample_count = 0;
   int unsigned               write_count = 0;
   int unsigned               pen_changes = 0;

   force_scale_pen_hysteresis uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_code    (req_raw_code),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_load_mn     (rsp_load_mn),
      .rsp_stamp_out   (rsp_stamp_out),
      .rsp_pen_is_down (rsp_pen_is_down),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver backpressure, one fresh decision per cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // offset, scale, truncate toward zero, clamp to the force range
   function automatic logic [FORCE_W-1:0] scaled_force(input logic signed [RAW_W-1:0] raw);
      longint delta;
      longint product;
      delta   = longint'(raw) - longint'(zero_offset_q);
      product = delta * longint'(scale_q);
      if (product <= 0)
         return '0;
      product = product >>> Q_FRAC_BITS;
      if (product > longint'(FORCE_MAX_MN))
         return FORCE_MAX_MN;
      return product[FORCE_W-1:0];
   endfunction

   // raw code that lands near a wanted force under the current settings
   function automatic logic signed [RAW_W-1:0] raw_for_force(input int unsigned target);
      longint code;
      if (scale_q <= 0)
         return RAW_W'($urandom);
      code = longint'(zero_offset_q)
             + ((longint'(target) <<< Q_FRAC_BITS) + longint'(scale_q) - 1) / longint'(scale_q);
      if (code > 64'sd8388607)
         code = 64'sd8388607;
      if (code < -64'sd8388608)
         code = -64'sd8388608;
      return code[RAW_W-1:0];
   endfunction

   // advance the pen machine by one sample and queue the result it owes
   task automatic predict_sample(input logic signed [RAW_W-1:0] raw,
                                 input logic [STAMP_W-1:0] stamp);
      pen_result_type due;
      pen_state_type  was;
      due.load_mn = scaled_force(raw);
      due.stamp   = stamp;
      was         = pen_q;
      if (pen_q == PEN_UP) begin
         if (due.load_mn >= down_thr_q) begin
            // counters stop at full scale
            down_run_q = (down_run_q == RUN_MAX) ? RUN_MAX : down_run_q + 1'b1;
            if (down_run_q >= debounce_q) begin
               pen_q    = PEN_DOWN;
               up_run_q = '0;
            end
         end else begin
            down_run_q = '0;
         end
      end else begin
         if (due.load_mn <= up_thr_q) begin
            up_run_q = (up_run_q == RUN_MAX) ? RUN_MAX : up_run_q + 1'b1;
            if (up_run_q >= debounce_q) begin
               pen_q      = PEN_UP;
               down_run_q = '0;
            end
         end else begin
            up_run_q = '0;
         end
      end
      if (pen_q != was)
         pen_changes++;
      due.pen = pen_q;
      pending_results.push_back(due);
   endtask

   // one sample transfer, then a random gap on the sender side
   // valid stays high into the next call when no gap is drawn
   task automatic send_sample(input logic signed [RAW_W-1:0] raw,
                              input logic [STAMP_W-1:0] stamp);
      req_valid     <= 1'b1;
      req_raw_code  <= raw;
      req_timestamp <= stamp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_sample(raw, stamp);
      sample_count++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // drop valid and let every owed result come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // setup cycle, access cycle, then the bus goes quiet before the task returns
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ZERO_OFFSET:    zero_offset_q = value[RAW_W-1:0];
         REG_SCALE_Q24:      scale_q       = value[SCALE_W-1:0];
         REG_DOWN_THRESHOLD: down_thr_q    = value[THR_W-1:0];
         REG_UP_THRESHOLD:   up_thr_q      = value[THR_W-1:0];
         REG_DEBOUNCE_COUNT: debounce_q    = value[RUN_W-1:0];
         default: ;
      endcase
      write_count++;
      @(posedge clock);
   endtask

   // result checker, compares each transfer with the oldest prediction
   always @(posedge clock) begin : check_result
      pen_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, got force %0d stamp %h pen %0b",
                     $time, rsp_load_mn, rsp_stamp_out, rsp_pen_is_down);
            fail_count++;
         end else begin
            due = pending_results.pop_front();
            if (rsp_load_mn !== due.load_mn) begin
               $display("%0t: load_mn expected %0d actual %0d",
                        $time, due.load_mn, rsp_load_mn);
               fail_count++;
            end
            if (rsp_stamp_out !== due.stamp) begin
               $display("%0t: stamp_out expected %h actual %h",
                        $time, due.stamp, rsp_stamp_out);
               fail_count++;
            end
            if (rsp_pen_is_down !== due.pen) begin
               $display("%0t: pen_is_down expected %0b actual %0b",
                        $time, due.pen, rsp_pen_is_down);
               fail_count++;
            end
         end
      end
   end

   // reset values: default scale is about 1 uN per lsb, press then release
   task automatic test_reset_defaults();
      send_sample(24'sd0, 32'h0000_0000);
      send_sample(24'sd8388607, 32'hFFFF_FFFF);
      send_sample(-24'sd8388608, $urandom);
      repeat (3) send_sample(24'sd200000, $urandom);
      repeat (3) send_sample(24'sd50000, $urandom);
   endtask

   // products far out of range both ways, upper pwdata bits ignored
   task automatic test_clamp_extremes();
      wait_idle();
      csr_write(REG_ZERO_OFFSET, 32'hA580_0000);
      csr_write(REG_SCALE_Q24, 32'h7FFF_FFFF);
      send_sample(24'sd8388607, 32'hFFFF_FFFF);
      send_sample(-24'sd8388608, 32'h0000_0000);
      wait_idle();
      csr_write(REG_ZERO_OFFSET, 32'h5A7F_FFFF);
      csr_write(REG_SCALE_Q24, 32'h8000_0000);
      // negative delta times most negative scale
      send_sample(-24'sd8388608, $urandom);
      wait_idle();
      csr_write(REG_SCALE_Q24, 32'hFFFF_FFFF);
      // tiny positive products truncate to zero
      send_sample(24'sd8388606, $urandom);
      send_sample(-24'sd8388608, $urandom);
   endtask

   // debounce of zero flips on a single qualifying sample
   task automatic test_zero_debounce();
      wait_idle();
      csr_write(REG_ZERO_OFFSET, 32'h0000_0000);
      csr_write(REG_SCALE_Q24, 32'h0100_0000);
      csr_write(REG_DOWN_THRESHOLD, 32'hC3A2_0064);
      csr_write(REG_UP_THRESHOLD, 32'h0000_0032);
      csr_write(REG_DEBOUNCE_COUNT, 32'hFFFF_FF00);
      send_sample(24'sd100, $urandom);
      send_sample(24'sd51, $urandom);
      send_sample(24'sd50, $urandom);
      send_sample(24'sd99, $urandom);
      send_sample(24'sd70000, $urandom);
      // threshold extremes, every sample qualifies
      wait_idle();
      csr_write(REG_DOWN_THRESHOLD, 32'h0000_0000);
      csr_write(REG_UP_THRESHOLD, 32'h0000_FFFF);
      send_sample(24'sd0, $urandom);
      send_sample(-24'sd5, $urandom);
      send_sample(24'sd8388607, $urandom);
   endtask

   // writes past the register map must leave the settings alone
   task automatic test_spare_registers();
      wait_idle();
      for (int i = int'(REG_SPARE_FIRST); i <= int'(REG_SPARE_LAST); i++)
         csr_write(CSR_IDX_W'(i), $urandom);
      send_sample(24'sd30000, $urandom);
      send_sample(-24'sd1, $urandom);
   endtask

   // fresh random settings, mostly sensible, sometimes at the edges
   task automatic pick_settings(input bit long_runs);
      logic [CSR_DATA_W-1:0] offset;
      logic [CSR_DATA_W-1:0] scale;
      logic [CSR_DATA_W-1:0] down;
      logic [CSR_DATA_W-1:0] up;
      logic [CSR_DATA_W-1:0] debounce;
      offset = ($urandom_range(3) == 0) ? $urandom
                                        : 32'($urandom_range(200000) - 100000);
      case ($urandom_range(7))
         0:       scale = $urandom;
         1:       scale = -32'($urandom_range(1 << 28, 1));
         default: scale = 32'($urandom_range(1 << 28, 1 << 12));
      endcase
      case ($urandom_range(5))
         0:       down = 0;
         1:       down = 32'hFFFF;
         2:       down = $urandom_range(65535);
         default: down = $urandom_range(5000, 50);
      endcase
      case ($urandom_range(5))
         0:       up = 0;
         1:       up = 32'hFFFF;
         2:       up = $urandom_range(65535);
         default: up = down[THR_W-1:0] * $urandom_range(90, 20) / 100;
      endcase
      if (long_runs)
         debounce = CSR_DATA_W'(RUN_MAX);
      else if ($urandom_range(3) == 0)
         debounce = $urandom_range(255);
      else
         debounce = $urandom_range(6, 0);
      // random junk above the width of each register narrower than the bus
      csr_write(REG_ZERO_OFFSET, ($urandom & 32'hFF00_0000) | (offset & 32'h00FF_FFFF));
      csr_write(REG_SCALE_Q24, scale);
      csr_write(REG_DOWN_THRESHOLD, ($urandom & 32'hFFFF_0000) | (down & 32'h0000_FFFF));
      csr_write(REG_UP_THRESHOLD, ($urandom & 32'hFFFF_0000) | (up & 32'h0000_FFFF));
      csr_write(REG_DEBOUNCE_COUNT, ($urandom & 32'hFFFF_FF00) | (debounce & 32'h0000_00FF));
   endtask

   // runs of presses, releases and in-between forces, with noise mixed in
   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input int unsigned settings,
                                      input bit with_long_runs);
      int unsigned     budget;
      int unsigned     made;
      int unsigned     run_len;
      int unsigned     target;
      int unsigned     pick;
      bit              long_runs;
      burst_kind_type  kind;
      logic signed [RAW_W-1:0] raw;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int s = 0; s < int'(settings); s++) begin
         long_runs = with_long_runs && (s == int'(settings) - 1);
         wait_idle();
         pick_settings(long_runs);
         budget = long_runs ? LONG_RUN_ITEMS : SETTING_ITEMS;
         made   = 0;
         while (made < budget) begin
            pick = $urandom_range(9);
            kind = (pick < 4) ? BURST_PRESS : (pick < 7) ? BURST_RELEASE :
                   (pick < 8) ? BURST_MIDDLE : BURST_NOISE;
            // long runs push a run counter all the way to full scale
            if (long_runs)
               run_len = $urandom_range(int'(RUN_MAX) + 3, 1);
            else if (debounce_q > 10)
               run_len = $urandom_range(12, 1);
            else
               run_len = $urandom_range(int'(debounce_q) + 3, 1);
            for (int n = 0; n < int'(run_len); n++) begin
               case (kind)
                  BURST_PRESS:   target = int'(down_thr_q) + $urandom_range(300);
                  BURST_RELEASE: target = $urandom_range(int'(up_thr_q));
                  BURST_MIDDLE:
                     target = (int'(down_thr_q) > int'(up_thr_q) + 1)
                              ? $urandom_range(int'(down_thr_q) - 1, int'(up_thr_q) + 1)
                              : $urandom_range(65535);
                  default:       target = 0;
               endcase
               // an odd stray sample breaks up the runs now and then
               if (kind == BURST_NOISE || $urandom_range(15) == 0)
                  raw = RAW_W'($urandom);
               else
                  raw = raw_for_force(target);
               send_sample(raw, $urandom);
               made++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_clamp_extremes();
      test_zero_debounce();
      test_spare_registers();
      // light sender gaps against heavy backpressure, then the reverse,
      // then full rate with one long-run setting at the end
      test_random_traffic(14, 59, 6, 1'b0);
      test_random_traffic(59, 14, 6, 1'b0);
      test_random_traffic(0, 0, 5, 1'b1);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d samples through %0d register writes, pen toggled %0d times",
               sample_count, write_count, pen_changes);
      $display("      %0d mismatches in %0d cycles", fail_count, cycle_count);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
rtl/fsh_pkg.sv
rtl/force_scale_pen_hysteresis.sv
rtl/fsh_checker.sv
tb/tb.sv
